/* rtl/ssd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider package
// Shared constants, sequencer states and the control word that the sequencer
// sends to the datapath.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_type;

endpackage : ssd_pkg
`default_nettype wire

/* rtl/ssd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider channels
// Valid/ready channels for the operand word and the result word.
// ----------------------------------------------------------------------------
interface ssd_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] numerator;
   logic signed [DATA_WIDTH-1:0] denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface : ssd_req_if

interface ssd_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic                         zero_divisor;
   logic                         overflowed;

   modport source (output valid, output quotient, output zero_divisor, output overflowed,
                   input ready);
   modport sink   (input valid, input quotient, input zero_divisor, input overflowed,
                   output ready);
endinterface : ssd_rsp_if
`default_nettype wire

/* rtl/ssd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider datapath
// Operand magnitudes, one shared shift-subtract unit producing one quotient
// bit per step, and the sign fix-up into the result register.
// ----------------------------------------------------------------------------
module ssd_core import ssd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire ctrl_type                     ctrl,
   input  wire logic signed [DATA_WIDTH-1:0] numerator,
   input  wire logic signed [DATA_WIDTH-1:0] denominator,
   output logic signed [DATA_WIDTH-1:0]      quotient,
   output logic                              zero_divisor,
   output logic                              overflowed
);

   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic [DATA_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic                  zdv_ff, zdv_in;
   logic                  ovf_ff, ovf_in;

   logic [DATA_WIDTH-1:0] num_u;
   logic [DATA_WIDTH-1:0] den_u;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;

   assign num_u   = $unsigned(numerator);
   assign den_u   = $unsigned(denominator);
   assign shifted = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = ~diff[DATA_WIDTH+1];

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quo_in  = quo_ff;
      zdv_in  = zdv_ff;
      ovf_in  = ovf_ff;
      if (ctrl.load) begin
         dvd_in  = num_u[DATA_WIDTH-1] ? (~num_u + 1'b1) : num_u;
         dvs_in  = den_u[DATA_WIDTH-1] ? (~den_u + 1'b1) : den_u;
         rem_in  = '0;
         neg_in  = num_u[DATA_WIDTH-1] ^ den_u[DATA_WIDTH-1];
         zero_in = (den_u == '0);
      end
      if (ctrl.step) begin
         rem_in = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         dvd_in = {dvd_ff[DATA_WIDTH-2:0], fits};
      end
      if (ctrl.finish) begin
         zdv_in = zero_ff;
         ovf_in = 1'b0;
         if (zero_ff) begin
            quo_in = '0;
         end else if (neg_ff) begin
            quo_in = ~dvd_ff + 1'b1;
         end else if (dvd_ff[DATA_WIDTH-1]) begin
            // most negative over minus one: saturate
            quo_in = MAX_POS;
            ovf_in = 1'b1;
         end else begin
            quo_in = dvd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quo_ff  <= quo_in;
      zdv_ff  <= zdv_in;
      ovf_ff  <= ovf_in;
   end

   assign quotient     = $signed(quo_ff);
   assign zero_divisor = zdv_ff;
   assign overflowed   = ovf_ff;

endmodule : ssd_core
`default_nettype wire

/* rtl/ssd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider sequencer
// Takes an operand word, runs one step per quotient bit, then hands the
// fixed-up result to the output register once it is free.
// ----------------------------------------------------------------------------
module ssd_ctrl import ssd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output ctrl_type  ctrl
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vld_ff, vld_in;
   logic             out_free;

   assign out_free = ~vld_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cnt_ff == '0) state_in = ST_FIX;
         end
         ST_FIX: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.step   = 1'b0;
      ctrl.finish = 1'b0;
      cnt_in      = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
            cnt_in    = LAST_BIT;
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff - 1'b1;
         end
         ST_FIX: begin
            ctrl.finish = out_free;
         end
         default: begin
            cnt_in = LAST_BIT;
         end
      endcase
      vld_in = ctrl.finish | (vld_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= LAST_BIT;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

endmodule : ssd_ctrl
`default_nettype wire

/* rtl/signed_shift_subtract_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Signed shift-subtract divider
// Signed integer division, quotient truncated toward zero, no remainder.
// ----------------------------------------------------------------------------
// A word is accepted and its operand magnitudes are loaded; then the single
// shift-subtract unit produces one quotient bit per cycle; then the sign
// fix-up writes the result to the output register. The fix-up cycle repeats
// while the output register still holds a result that has not been taken.
// The block takes no new word while a division runs; a finished result
// waits in the output register, so the next word is taken while it is still
// held. A zero divisor gives quotient 0 with zero_divisor set; the most
// negative value divided by minus one gives the largest positive value with
// overflowed set.
module signed_shift_subtract_divider import ssd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   ssd_req_if.sink   req_chan,
   ssd_rsp_if.source rsp_chan
);

   ctrl_type ctrl;

   ssd_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   ssd_core #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock        (clock),
      .ctrl         (ctrl),
      .numerator    (req_chan.numerator),
      .denominator  (req_chan.denominator),
      .quotient     (rsp_chan.quotient),
      .zero_divisor (rsp_chan.zero_divisor),
      .overflowed   (rsp_chan.overflowed)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("divider took a word while busy");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.zero_divisor && rsp_chan.overflowed))
      else $error("both result flags set");

   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.zero_divisor) |-> (rsp_chan.quotient == '0))
      else $error("zero divisor with non-zero quotient");

   a_finish_only_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten before it was taken");

endmodule : signed_shift_subtract_divider
`default_nettype wire
